[rtl/core/csg_pkg.sv]
// Shared types and constants for the circle window span generator.
// No dependencies.
package csg_pkg;

	// Screen width used to clamp the window edges
	localparam int SCREEN_WIDTH = 240;
	localparam int SW_W = 11;
	localparam logic [SW_W-1:0] SCREEN_WIDTH_C = SW_W'(SCREEN_WIDTH);

	// Square root pipeline: one cell per result bit
	localparam int RAD_W = 16;
	localparam int ROOT_BITS = 8;
	localparam int NUM_CELLS = ROOT_BITS;
	localparam int STEP_W = 3;

	// Configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_LINE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LAST_LINE  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_X   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS     = 3'd4;
	localparam int CFG_DATA_W = 11;

	// Configuration register file contents
	typedef struct packed {
		logic [7:0]        first_line;
		logic [7:0]        last_line;
		logic signed [10:0] center_x;
		logic [7:0]        center_y;
		logic [7:0]        radius;
	} csg_cfg_t;

	// Item carried along the square root chain
	typedef struct packed {
		logic             in_span;
		logic [RAD_W-1:0] rem;
		logic [RAD_W-1:0] root;
	} csg_sqrt_t;

endpackage

[rtl/core/circle_window_span_generator_top.sv]
// Top level of the circle window span generator: configuration registers,
// front end, chain of square root cells and output stage. Depends on csg_pkg.
//
// Usage:
//   - Input channel (in_valid/in_ready, line): one scanline number per item.
//   - Output channel (out_valid/out_ready, in_span, left_edge, right_edge):
//     one result per item, in input order.
//   - Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): cfg_ready is
//     always high; index 0 first_line, 1 last_line, 2 center_x, 3 center_y,
//     4 radius; other indexes are ignored. Write only while the block is idle.
// Pipeline: an accepted item passes two front stages, eight square root
// cells and one output register (eleven registers) before out_valid rises.
// Throughput: one item per cycle; every stage has its own valid bit and the
// chain advances whenever the next stage is empty or moving.
// Reset: all stages empty, registers at first_line 0, last_line 0,
// center_x 120, center_y 80, radius 0.
// Receiver stall: the output register holds; bubbles ahead of it are
// squeezed out, and in_ready drops only once all eleven stages hold items.
module circle_window_span_generator_top import csg_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            line,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  in_span,
	output logic [7:0]            left_edge,
	output logic [7:0]            right_edge,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	csg_cfg_t  cfg_q;
	logic      vld [0:NUM_CELLS];
	logic      rdy [0:NUM_CELLS];
	csg_sqrt_t dat [0:NUM_CELLS];

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.first_line <= 8'd0;
			cfg_q.last_line  <= 8'd0;
			cfg_q.center_x   <= 11'sd120;
			cfg_q.center_y   <= 8'd80;
			cfg_q.radius     <= 8'd0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_FIRST_LINE: cfg_q.first_line <= cfg_data[7:0];
				REG_LAST_LINE:  cfg_q.last_line  <= cfg_data[7:0];
				REG_CENTER_X:   cfg_q.center_x   <= $signed(cfg_data[10:0]);
				REG_CENTER_Y:   cfg_q.center_y   <= cfg_data[7:0];
				REG_RADIUS:     cfg_q.radius     <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	// Span test and radicand
	csg_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.up_valid (in_valid),
		.up_ready (in_ready),
		.line     (line),
		.dn_valid (vld[0]),
		.dn_ready (rdy[0]),
		.dn_data  (dat[0])
	);

	// Square root chain, one result bit per cell
	for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
		csg_sqrt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.step     (STEP_W'(k)),
			.up_valid (vld[k]),
			.up_ready (rdy[k]),
			.up_data  (dat[k]),
			.dn_valid (vld[k+1]),
			.dn_ready (rdy[k+1]),
			.dn_data  (dat[k+1])
		);
	end

	// Edge clamp and output register
	csg_edge u_edge (
		.clk        (clk),
		.arst_n     (arst_n),
		.center_x   (cfg_q.center_x),
		.up_valid   (vld[NUM_CELLS]),
		.up_ready   (rdy[NUM_CELLS]),
		.up_data    (dat[NUM_CELLS]),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.in_span    (in_span),
		.left_edge  (left_edge),
		.right_edge (right_edge)
	);

	// Outside the span both edges are zero
	a_zero_outside: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !in_span |-> left_edge == 8'd0 && right_edge == 8'd0)
		else $error("edge nonzero outside span");

	// Inside the span the window is never inverted
	a_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && in_span |-> left_edge <= right_edge)
		else $error("left edge beyond right edge");

	// An empty output register means the whole chain can move
	a_ready_chain: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

endmodule

[rtl/core/csg_front.sv]
// Front end: span test, |dy| and radicand r^2 - dy^2, two pipeline stages.
// Depends on csg_pkg.
module csg_front import csg_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  csg_cfg_t  cfg,
	input  logic      up_valid,
	output logic      up_ready,
	input  logic [7:0] line,
	output logic      dn_valid,
	input  logic      dn_ready,
	output csg_sqrt_t dn_data
);

	logic       valid_s1;
	logic       span_s1;
	logic [7:0] dya_s1;
	logic       valid_s2;
	logic       span_s2;
	logic [RAD_W-1:0] rad_s2;

	logic       ready_s1;
	logic       ready_s2;
	logic       span_c;
	logic [7:0] dya_c;
	logic [8:0] line_r;
	logic [8:0] cy_r;
	logic [RAD_W-1:0] rsq;
	logic [RAD_W-1:0] dsq;

	// Span test: first <= line < last, cy - r <= line < cy + r
	always_comb begin
		line_r = 9'(line) + 9'(cfg.radius);
		cy_r   = 9'(cfg.center_y) + 9'(cfg.radius);
		span_c = (line >= cfg.first_line) && (line < cfg.last_line)
			&& (line_r >= 9'(cfg.center_y)) && (9'(line) < cy_r);
		if (line >= cfg.center_y) begin
			dya_c = line - cfg.center_y;
		end else begin
			dya_c = cfg.center_y - line;
		end
		if (!span_c) begin
			dya_c = '0;
		end
	end

	assign ready_s2 = !valid_s2 || dn_ready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign up_ready = ready_s1;

	// Stage 1: span flag and |dy|
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && up_valid) begin
			span_s1 <= span_c;
			dya_s1  <= dya_c;
		end
	end

	// Stage 2: radicand
	assign rsq = RAD_W'(cfg.radius) * RAD_W'(cfg.radius);
	assign dsq = RAD_W'(dya_s1) * RAD_W'(dya_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			span_s2 <= span_s1;
			rad_s2  <= rsq - dsq;
		end
	end

	assign dn_valid        = valid_s2;
	assign dn_data.in_span = span_s2;
	assign dn_data.rem     = rad_s2;
	assign dn_data.root    = '0;

endmodule

[rtl/core/csg_sqrt_cell.sv]
// One step of the digit-by-digit square root, registered with its own valid.
// Depends on csg_pkg.
module csg_sqrt_cell import csg_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [STEP_W-1:0] step,
	input  logic              up_valid,
	output logic              up_ready,
	input  csg_sqrt_t         up_data,
	output logic              dn_valid,
	input  logic              dn_ready,
	output csg_sqrt_t         dn_data
);

	logic              valid_q;
	csg_sqrt_t         data_q;
	csg_sqrt_t         next_c;
	logic [4:0]        shift;
	logic [RAD_W-1:0]  bitv;
	logic [RAD_W:0]    trial;

	// Trial subtract of root + bit at this cell's bit position
	always_comb begin
		shift = 5'd14 - {1'b0, step, 1'b0};
		bitv  = RAD_W'(1) << shift;
		trial = {1'b0, up_data.root} + {1'b0, bitv};
		next_c.in_span = up_data.in_span;
		if ({1'b0, up_data.rem} >= trial) begin
			next_c.rem  = up_data.rem - trial[RAD_W-1:0];
			next_c.root = (up_data.root >> 1) + bitv;
		end else begin
			next_c.rem  = up_data.rem;
			next_c.root = up_data.root >> 1;
		end
	end

	assign up_ready = !valid_q || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_q <= next_c;
		end
	end

	assign dn_valid = valid_q;
	assign dn_data  = data_q;

endmodule

[rtl/core/csg_edge.sv]
// Output stage: center_x -/+ s clamped to the screen, held in the output register.
// Depends on csg_pkg.
module csg_edge import csg_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic signed [10:0] center_x,
	input  logic               up_valid,
	output logic               up_ready,
	input  csg_sqrt_t          up_data,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               in_span,
	output logic [7:0]         left_edge,
	output logic [7:0]         right_edge
);

	logic              valid_q;
	logic              span_q;
	logic [7:0]        left_q;
	logic [7:0]        right_q;
	logic [7:0]        s;
	logic signed [12:0] lo_c;
	logic signed [12:0] hi_c;
	logic [7:0]        left_c;
	logic [7:0]        right_c;

	function automatic logic [7:0] clamp_edge(input logic signed [12:0] v);
		logic [7:0] r;
		if (v < 13'sd0) begin
			r = '0;
		end else if (v > $signed(13'(SCREEN_WIDTH_C))) begin
			r = SCREEN_WIDTH_C[7:0];
		end else begin
			r = v[7:0];
		end
		return r;
	endfunction

	// Edges; both forced to zero outside the span
	always_comb begin
		s    = up_data.root[7:0];
		lo_c = 13'(center_x) - $signed({5'b0, s});
		hi_c = 13'(center_x) + $signed({5'b0, s});
		if (up_data.in_span) begin
			left_c  = clamp_edge(lo_c);
			right_c = clamp_edge(hi_c);
		end else begin
			left_c  = '0;
			right_c = '0;
		end
	end

	assign up_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			span_q  <= up_data.in_span;
			left_q  <= left_c;
			right_q <= right_c;
		end
	end

	assign out_valid  = valid_q;
	assign in_span    = span_q;
	assign left_edge  = left_q;
	assign right_edge = right_q;

endmodule

[tb/circle_window_span_generator_top_tb.sv]
// Self-checking testbench for circle_window_span_generator_top: directed scanlines, then
// random circles and lines, checked against fixed values or an in-bench span predictor.
// Depends on csg_pkg and the RTL top level only.
module circle_window_span_generator_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import csg_pkg::*;

	localparam int HALF_PERIOD = 2;
	localparam int RESET_CYCLES = 9;
	localparam int LATENCY = 11;
	localparam int NUM_PHASES = 16;
	localparam int LINES_PER_PHASE = 88;
	localparam int DRAIN_LIMIT = 4000;
	// timeout sized well above the slowest run, with every gap and stall at its maximum
	localparam int TIMEOUT_NS = 2_000_000;

	// indexes past the register list; writes there must be ignored
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = 3'd7;

	typedef struct packed {
		logic       in_span;
		logic [7:0] left_edge;
		logic [7:0] right_edge;
	} span_t;

	typedef struct packed {
		csg_cfg_t   cfg;
		logic [7:0] ln;
		logic       typed;
		span_t      want;
	} dir_row_t;

	localparam span_t NO_SPAN = '{1'b0, 8'd0, 8'd0};

	// circle setups for the directed part: first, last, center_x, center_y, radius
	localparam csg_cfg_t CFG_RESET  = '{8'd0, 8'd0, 11'sd120, 8'd80, 8'd0};
	localparam csg_cfg_t CFG_MID    = '{8'd0, 8'd255, 11'sd120, 8'd80, 8'd50};
	localparam csg_cfg_t CFG_TOP    = '{8'd10, 8'd200, 11'sd120, 8'd5, 8'd20};
	localparam csg_cfg_t CFG_EMPTY  = '{8'd100, 8'd50, 11'sd120, 8'd80, 8'd100};
	localparam csg_cfg_t CFG_FAR_L  = '{8'd0, 8'd255, -11'sd1024, 8'd128, 8'd181};
	localparam csg_cfg_t CFG_FAR_R  = '{8'd0, 8'd255, 11'sd1023, 8'd128, 8'd181};
	localparam csg_cfg_t CFG_HUGE   = '{8'd0, 8'd255, 11'sd120, 8'd128, 8'd255};
	localparam csg_cfg_t CFG_CORNER = '{8'd0, 8'd255, -11'sd5, 8'd255, 8'd3};

	// rows with typed == 0 are checked against the predictor
	localparam int DIR_ROWS = 24;
	localparam dir_row_t DIRECTED [DIR_ROWS] = '{
		'{CFG_RESET, 8'd0, 1'b1, NO_SPAN},
		'{CFG_RESET, 8'd80, 1'b1, NO_SPAN},
		'{CFG_RESET, 8'd255, 1'b1, NO_SPAN},
		'{CFG_MID, 8'd80, 1'b1, '{1'b1, 8'd70, 8'd170}},
		'{CFG_MID, 8'd30, 1'b1, '{1'b1, 8'd120, 8'd120}},
		'{CFG_MID, 8'd29, 1'b1, NO_SPAN},
		'{CFG_MID, 8'd129, 1'b0, NO_SPAN},
		'{CFG_MID, 8'd130, 1'b1, NO_SPAN},
		'{CFG_MID, 8'd100, 1'b0, NO_SPAN},
		'{CFG_TOP, 8'd9, 1'b1, NO_SPAN},
		'{CFG_TOP, 8'd10, 1'b0, NO_SPAN},
		'{CFG_TOP, 8'd24, 1'b0, NO_SPAN},
		'{CFG_TOP, 8'd25, 1'b1, NO_SPAN},
		'{CFG_EMPTY, 8'd80, 1'b1, NO_SPAN},
		'{CFG_EMPTY, 8'd100, 1'b1, NO_SPAN},
		'{CFG_FAR_L, 8'd128, 1'b1, '{1'b1, 8'd0, 8'd0}},
		'{CFG_FAR_R, 8'd128, 1'b1, '{1'b1, 8'd240, 8'd240}},
		'{CFG_FAR_R, 8'd0, 1'b0, NO_SPAN},
		'{CFG_HUGE, 8'd128, 1'b1, '{1'b1, 8'd0, 8'd240}},
		'{CFG_HUGE, 8'd0, 1'b0, NO_SPAN},
		'{CFG_HUGE, 8'd255, 1'b1, NO_SPAN},
		'{CFG_HUGE, 8'd254, 1'b0, NO_SPAN},
		'{CFG_CORNER, 8'd252, 1'b0, NO_SPAN},
		'{CFG_CORNER, 8'd255, 1'b1, NO_SPAN}
	};

	// extreme register settings opening the random part
	localparam csg_cfg_t EXTREMES [4] = '{
		'{8'd0, 8'd0, -11'sd1024, 8'd0, 8'd0},
		'{8'd255, 8'd255, 11'sd1023, 8'd255, 8'd255},
		'{8'd0, 8'd255, 11'sd1023, 8'd255, 8'd255},
		'{8'd0, 8'd255, -11'sd1024, 8'd0, 8'd181}
	};

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic [7:0]            line;
	logic                  out_valid;
	logic                  out_ready;
	logic                  in_span;
	logic [7:0]            left_edge;
	logic [7:0]            right_edge;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	csg_cfg_t cfg_now;        // register contents as the block should hold them
	span_t    pending_span;   // expectation for the line now on the input port
	span_t    spans_in_flight[$];
	span_t    span_want;
	int       mismatches = 0;
	bit       tx_burst;
	bit       rx_burst;

	circle_window_span_generator_top i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.line       (line),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.in_span    (in_span),
		.left_edge  (left_edge),
		.right_edge (right_edge),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always #(HALF_PERIOD) clk = ~clk;

	task automatic report_mismatch(input string what);
		mismatches++;
		$display("MISMATCH @%0t: %s", $time, what);
	endtask

	// saturate an edge to the screen, then keep the low 8 bits
	function automatic logic [7:0] clamp_edge(input int v);
		if (v < 0) return 8'd0;
		if (v > SCREEN_WIDTH) v = SCREEN_WIDTH;
		return 8'(v);
	endfunction

	// window edges of the circle on one scanline
	function automatic span_t predict_span(input csg_cfg_t c, input logic [7:0] ln);
		int    top, bottom, cy, r, dy, chord_sq, half, cx;
		span_t res;
		res = NO_SPAN;
		cy = int'(c.center_y);
		r = int'(c.radius);
		top = int'(c.first_line);
		bottom = int'(c.last_line);
		if (cy - r > top) top = cy - r;
		if (cy + r < bottom) bottom = cy + r;
		if (int'(ln) < top || int'(ln) >= bottom) return res;
		dy = int'(ln) - cy;
		chord_sq = r * r - dy * dy;
		// largest half chord whose square fits, one bit at a time
		half = 0;
		for (int b = 7; b >= 0; b--) begin
			if ((half + (1 << b)) * (half + (1 << b)) <= chord_sq) half += 1 << b;
		end
		cx = int'($signed(c.center_x));
		res.in_span = 1'b1;
		res.left_edge = clamp_edge(cx - half);
		res.right_edge = clamp_edge(cx + half);
		return res;
	endfunction

	// mirror of a register write, spare indexes leave everything alone
	function automatic void store_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_FIRST_LINE: cfg_now.first_line = data[7:0];
			REG_LAST_LINE:  cfg_now.last_line = data[7:0];
			REG_CENTER_X:   cfg_now.center_x = data;
			REG_CENTER_Y:   cfg_now.center_y = data[7:0];
			REG_RADIUS:     cfg_now.radius = data[7:0];
			default: ;
		endcase
	endfunction

	// write all five registers plus one spare index; 8-bit registers get junk high bits
	task automatic apply_config(input csg_cfg_t c);
		logic [CFG_IDX_W-1:0]  regs [6];
		logic [CFG_DATA_W-1:0] vals [6];
		regs[0] = REG_FIRST_LINE; vals[0] = {3'($urandom), c.first_line};
		regs[1] = REG_LAST_LINE;  vals[1] = {3'($urandom), c.last_line};
		regs[2] = REG_CENTER_X;   vals[2] = c.center_x;
		regs[3] = REG_CENTER_Y;   vals[3] = {3'($urandom), c.center_y};
		regs[4] = REG_RADIUS;     vals[4] = {3'($urandom), c.radius};
		regs[5] = CFG_IDX_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST));
		vals[5] = CFG_DATA_W'($urandom);
		for (int k = 0; k < 6; k++) begin
			cfg_valid <= 1'b1;
			cfg_index <= regs[k];
			cfg_data <= vals[k];
			do @(posedge clk); while (!cfg_ready);
			store_reg(regs[k], vals[k]);
		end
		cfg_valid <= 1'b0;
	endtask

	// drop valid and wait until every scanline result has come back
	task automatic wait_idle();
		in_valid <= 1'b0;
		do @(posedge clk); while (spans_in_flight.size() != 0);
	endtask

	// offer one scanline; valid stays high afterwards unless the next item idles first
	task automatic send_line(input logic [7:0] ln, input span_t want);
		int gap;
		gap = tx_burst ? 0 : $urandom_range(0, 7);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		line <= ln;
		pending_span <= want;
		do @(posedge clk); while (!in_ready);
	endtask

	function automatic csg_cfg_t random_circle();
		csg_cfg_t c;
		int       pick;
		logic [7:0] a, b;
		c.center_y = 8'($urandom);
		pick = $urandom_range(0, 9);
		if (pick < 2) c.radius = 8'($urandom_range(0, 8));
		else if (pick < 8) c.radius = 8'($urandom_range(9, 181));
		else c.radius = 8'($urandom_range(182, 255));
		if ($urandom_range(0, 3) == 0) c.center_x = 11'($urandom);
		else c.center_x = 11'($urandom_range(0, SCREEN_WIDTH));
		a = 8'($urandom);
		b = 8'($urandom);
		pick = $urandom_range(0, 3);
		if (pick < 2) begin
			c.first_line = 8'd0;
			c.last_line = 8'd255;
		end else if (pick == 2) begin
			c.first_line = (a < b) ? a : b;
			c.last_line = (a < b) ? b : a;
		end else begin
			c.first_line = a;
			c.last_line = b;
		end
		return c;
	endfunction

	// mostly lines around the circle, some anywhere
	function automatic logic [7:0] random_line(input csg_cfg_t c);
		int lo, hi;
		if ($urandom_range(0, 3) == 0) return 8'($urandom);
		lo = int'(c.center_y) - int'(c.radius) - 2;
		hi = int'(c.center_y) + int'(c.radius) + 2;
		if (lo < 0) lo = 0;
		if (hi > 255) hi = 255;
		return 8'($urandom_range(lo, hi));
	endfunction

	// queue expectations on input accept, check results on output accept
	always @(posedge clk) begin
		if (in_valid && in_ready) spans_in_flight.push_back(pending_span);
		if (out_valid && out_ready) begin
			if (spans_in_flight.size() == 0) begin
				report_mismatch("result with no scanline pending");
			end else begin
				span_want = spans_in_flight.pop_front();
				if (in_span !== span_want.in_span)
					report_mismatch($sformatf("in_span got %0b want %0b",
						in_span, span_want.in_span));
				if (left_edge !== span_want.left_edge)
					report_mismatch($sformatf("left_edge got %0d want %0d",
						left_edge, span_want.left_edge));
				if (right_edge !== span_want.right_edge)
					report_mismatch($sformatf("right_edge got %0d want %0d",
						right_edge, span_want.right_edge));
			end
		end
	end

	// receiver: random stall before each result, none in burst stretches
	initial begin
		int stall;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = rx_burst ? 0 : $urandom_range(0, 7);
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin
		#(TIMEOUT_NS);
		$display("Verification failed");
		$finish;
	end

	// main sequence
	initial begin
		csg_cfg_t c;
		arst_n = 1'b0;
		in_valid = 1'b0;
		line = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		pending_span = NO_SPAN;
		tx_burst = 1'b0;
		rx_burst = 1'b0;
		cfg_now = CFG_RESET;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows, reconfigure only when the circle changes
		for (int i = 0; i < DIR_ROWS; i++) begin
			if (DIRECTED[i].cfg != cfg_now) begin
				wait_idle();
				apply_config(DIRECTED[i].cfg);
			end
			send_line(DIRECTED[i].ln, DIRECTED[i].typed ? DIRECTED[i].want
				: predict_span(cfg_now, DIRECTED[i].ln));
		end

		// random phases: extremes first, then random circles
		for (int p = 0; p < NUM_PHASES; p++) begin
			c = (p < 4) ? EXTREMES[p] : random_circle();
			wait_idle();
			apply_config(c);
			tx_burst = ($urandom_range(0, 3) == 0);
			rx_burst = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < LINES_PER_PHASE; i++) begin
				line_pick: begin
					logic [7:0] ln;
					ln = random_line(cfg_now);
					send_line(ln, predict_span(cfg_now, ln));
				end
			end
		end

		// drain, then look for stray results
		in_valid <= 1'b0;
		for (int w = 0; w < DRAIN_LIMIT && spans_in_flight.size() != 0; w++)
			@(posedge clk);
		if (spans_in_flight.size() != 0)
			report_mismatch($sformatf("%0d scanline results never arrived",
				spans_in_flight.size()));
		repeat (LATENCY + 8) @(posedge clk);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
